// ----- rtl/jjpd_pkg.sv -----
// Shared types, constants and saturation helpers of the joystick jog PD joint controller.
`default_nettype none

package jjpd_pkg;

  localparam int JOINTS     = 3;
  localparam int AXIS_W     = 16;
  localparam int ANGLE_W    = 24;
  localparam int GAIN_W     = 24;
  localparam int REF_W      = 32;
  localparam int CMD_W      = 32;
  localparam int X_W        = 40;
  localparam int LO_W       = 20;
  localparam int MUL_A_W    = X_W - LO_W + 1;
  localparam int MUL_B_W    = GAIN_W + 1;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = MUL_P_W + LO_W;
  localparam int TERM_W     = 47;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [AXIS_W-1:0] DEAD_Q = 16'd6554;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN_A = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN_B = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN_C = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP_GAIN_A = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP_GAIN_B = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP_GAIN_C = 4'd7;

  localparam logic [1:0] MODE_TORQUE   = 2'd0;
  localparam logic [1:0] MODE_VELOCITY = 2'd1;
  localparam logic [1:0] MODE_POSITION = 2'd2;

  typedef struct packed {
    logic [1:0]                    drive_mode;
    logic [GAIN_W-1:0]             rate_scale;
    logic [JOINTS-1:0][GAIN_W-1:0] prop_gain;
    logic [JOINTS-1:0][GAIN_W-1:0] damp_gain;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_JNUM, S_JEST, S_JFIX, S_REF,
    S_ERR, S_PLO, S_PHI, S_PRND,
    S_DIFF, S_RLO, S_RHI, S_RRND,
    S_DLO, S_DHI, S_DRND,
    S_OUT, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_CAPTURE, DP_JOG_NUM, DP_JOG_EST, DP_JOG_FIX, DP_REF_UPD,
    DP_X_ERR, DP_X_DIFF, DP_MUL_LO, DP_MUL_HI,
    DP_RND_X, DP_RND_T, DP_RND_ACC,
    DP_OUT_SUB, DP_OUT_ACC, DP_OUT_REF, DP_OUT_ZERO, DP_PUBLISH
  } dp_op_t;

  typedef enum logic [1:0] {
    COEF_RATE, COEF_KP, COEF_KD
  } coef_sel_t;

  typedef struct packed {
    dp_op_t     op;
    coef_sel_t  coef;
    logic       sh12;
    logic [1:0] joint;
  } dp_cmd_t;

  function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-CMD_W+1){1'b0}}, {(CMD_W-1){1'b1}}};
    lo = {{(ACC_W-CMD_W+1){1'b1}}, {(CMD_W-1){1'b0}}};
    if (v > hi) return {1'b0, {(CMD_W-1){1'b1}}};
    if (v < lo) return {1'b1, {(CMD_W-1){1'b0}}};
    return v[CMD_W-1:0];
  endfunction

  function automatic logic signed [X_W-1:0] sat_x(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-X_W+1){1'b0}}, {(X_W-1){1'b1}}};
    lo = {{(ACC_W-X_W+1){1'b1}}, {(X_W-1){1'b0}}};
    if (v > hi) return {1'b0, {(X_W-1){1'b1}}};
    if (v < lo) return {1'b1, {(X_W-1){1'b0}}};
    return v[X_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/jjpd_dp.sv -----
// Datapath: jog reference update, shared multiplier with accumulator, result registers.
`default_nettype none

module jjpd_dp
  import jjpd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  input  cfg_t                      cfg,
  input  logic signed [AXIS_W-1:0]  stick_axis,
  input  logic signed [ANGLE_W-1:0] angle_a,
  input  logic signed [ANGLE_W-1:0] angle_b,
  input  logic signed [ANGLE_W-1:0] angle_c,
  output logic signed [CMD_W-1:0]   command_a,
  output logic signed [CMD_W-1:0]   command_b,
  output logic signed [CMD_W-1:0]   command_c
);

  // jog delta = round(|axis| * 2^(F+1) / 327680000), reduced by a common power of two
  localparam int JS = (ANGLE_FRAC_BITS + 1 < 15) ? ANGLE_FRAC_BITS + 1 : 15;
  localparam int JX = ANGLE_FRAC_BITS + 1 - JS;
  localparam int JNUM_W = 16 + JX;
  localparam longint JDEN_L = 64'd327680000 >> JS;
  localparam logic [JNUM_W-1:0] JDEN = JNUM_W'(JDEN_L);
  localparam logic [JNUM_W-1:0] JHALF = JNUM_W'(JDEN_L / 2);
  localparam logic [JNUM_W-1:0] JRECIP = JNUM_W'((64'd1 << JNUM_W) / JDEN_L);
  localparam longint STEP_L = ((64'd1 << (ANGLE_FRAC_BITS + 1)) + 64'd5000) / 64'd10000;
  localparam logic signed [ACC_W-1:0] STEP_Q = ACC_W'(STEP_L);
  localparam logic signed [REF_W-1:0] UPPER_Q = REF_W'(((64'd1 << ANGLE_FRAC_BITS) * 4) / 5);

  logic signed [AXIS_W-1:0]  axis_r;
  logic signed [ANGLE_W-1:0] q_r    [JOINTS];
  logic signed [ANGLE_W-1:0] prev_r [JOINTS];
  logic signed [REF_W-1:0]   ref_r  [JOINTS];
  logic signed [CMD_W-1:0]   res    [JOINTS];
  logic                      started;
  logic [JNUM_W-1:0]         jnum;
  logic [JNUM_W-1:0]         jest;
  logic                      jneg;
  logic                      jdead;
  logic signed [JNUM_W:0]    delta;
  logic signed [X_W-1:0]     x;
  logic signed [ACC_W-1:0]   acc;
  logic signed [TERM_W-1:0]  term;

  logic [AXIS_W-1:0]         axis_mag;
  logic [2*JNUM_W-1:0]       jprod;
  logic [2*JNUM_W-1:0]       jchk;
  logic [2*JNUM_W-1:0]       jrem;
  logic [JNUM_W-1:0]         jfix;
  logic signed [JNUM_W:0]    delta_mag;
  logic signed [JNUM_W:0]    delta_next;
  logic signed [ACC_W-1:0]   ref_sum [JOINTS];
  logic signed [REF_W-1:0]   ref_upd [JOINTS];
  logic signed [ANGLE_W-1:0] q_sel;
  logic signed [ANGLE_W-1:0] prev_sel;
  logic signed [REF_W-1:0]   ref_sel;
  logic [GAIN_W-1:0]         coef;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_lo;
  logic signed [ACC_W-1:0]   prod_hi;
  logic signed [ACC_W-1:0]   rnd_half;
  logic signed [ACC_W-1:0]   rnd_sum;
  logic signed [ACC_W-1:0]   rnd_val;
  logic signed [X_W-1:0]     err_w;
  logic signed [X_W-1:0]     diff_w;
  logic signed [ACC_W-1:0]   sub_w;

  assign axis_mag = axis_r[AXIS_W-1] ? AXIS_W'(-axis_r) : axis_r;

  assign jprod = jnum * JRECIP;
  assign jchk  = jest * JDEN;
  assign jrem  = {{JNUM_W{1'b0}}, jnum} - jchk;
  assign jfix  = (jrem >= {{JNUM_W{1'b0}}, JDEN}) ? jest + 1'b1 : jest;
  assign delta_mag = {1'b0, jfix};

  always_comb begin
    if (jdead) begin
      delta_next = '0;
    end else if (jneg) begin
      delta_next = -delta_mag;
    end else begin
      delta_next = delta_mag;
    end
  end

  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      ref_sum[j] = $signed({{(ACC_W-REF_W){ref_r[j][REF_W-1]}}, ref_r[j]})
                 + $signed({{(ACC_W-JNUM_W-1){delta[JNUM_W]}}, delta});
      if ($signed({{(REF_W-ANGLE_W){q_r[j][ANGLE_W-1]}}, q_r[j]}) > UPPER_Q) begin
        ref_sum[j] = ref_sum[j] - STEP_Q;
      end else if (q_r[j][ANGLE_W-1]) begin
        ref_sum[j] = ref_sum[j] + STEP_Q;
      end
      ref_upd[j] = sat_cmd(ref_sum[j]);
    end
  end

  always_comb begin
    case (cmd.joint)
      2'd0: begin
        q_sel    = q_r[0];
        prev_sel = prev_r[0];
        ref_sel  = ref_r[0];
      end
      2'd1: begin
        q_sel    = q_r[1];
        prev_sel = prev_r[1];
        ref_sel  = ref_r[1];
      end
      default: begin
        q_sel    = q_r[2];
        prev_sel = prev_r[2];
        ref_sel  = ref_r[2];
      end
    endcase
  end

  always_comb begin
    case (cmd.coef)
      COEF_KP: coef = cfg.prop_gain[cmd.joint];
      COEF_KD: coef = cfg.damp_gain[cmd.joint];
      default: coef = cfg.rate_scale;
    endcase
  end

  // 40-bit operand goes through the 21x25 multiplier as low then high half
  assign mul_a = (cmd.op == DP_MUL_HI) ? $signed({x[X_W-1], x[X_W-1:LO_W]})
                                       : $signed({1'b0, x[LO_W-1:0]});
  assign mul_b = $signed({1'b0, coef});
  assign prod  = mul_a * mul_b;
  assign prod_lo = $signed({{LO_W{prod[MUL_P_W-1]}}, prod});
  assign prod_hi = $signed({prod, {LO_W{1'b0}}});

  // round half up on a right shift by 8 or 12
  assign rnd_half = cmd.sh12 ? $signed(ACC_W'(2048)) : $signed(ACC_W'(128));
  assign rnd_sum  = acc + rnd_half;
  assign rnd_val  = cmd.sh12 ? (rnd_sum >>> 12) : (rnd_sum >>> 8);

  assign err_w  = $signed({{(X_W-REF_W){ref_sel[REF_W-1]}}, ref_sel})
                - $signed({{(X_W-ANGLE_W){q_sel[ANGLE_W-1]}}, q_sel});
  assign diff_w = $signed({{(X_W-ANGLE_W){q_sel[ANGLE_W-1]}}, q_sel})
                - $signed({{(X_W-ANGLE_W){prev_sel[ANGLE_W-1]}}, prev_sel});
  assign sub_w  = $signed({{(ACC_W-TERM_W){term[TERM_W-1]}}, term}) - acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (cmd.op == DP_JOG_NUM) begin
      started <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        axis_r <= stick_axis;
        q_r[0] <= angle_a;
        q_r[1] <= angle_b;
        q_r[2] <= angle_c;
      end
      DP_JOG_NUM: begin
        jnum  <= (JNUM_W'(axis_mag) << JX) + JHALF;
        jneg  <= axis_r[AXIS_W-1];
        jdead <= axis_mag < DEAD_Q;
        if (!started) begin
          for (int j = 0; j < JOINTS; j++) begin
            ref_r[j]  <= $signed({{(REF_W-ANGLE_W){q_r[j][ANGLE_W-1]}}, q_r[j]});
            prev_r[j] <= q_r[j];
          end
        end
      end
      DP_JOG_EST: jest  <= jprod[2*JNUM_W-1:JNUM_W];
      DP_JOG_FIX: delta <= delta_next;
      DP_REF_UPD: begin
        for (int j = 0; j < JOINTS; j++) begin
          ref_r[j] <= ref_upd[j];
        end
      end
      DP_X_ERR: x <= err_w;
      DP_X_DIFF: begin
        x <= diff_w;
        prev_r[cmd.joint] <= q_sel;
      end
      DP_MUL_LO:   acc  <= prod_lo;
      DP_MUL_HI:   acc  <= acc + prod_hi;
      DP_RND_X:    x    <= sat_x(rnd_val);
      DP_RND_T:    term <= rnd_val[TERM_W-1:0];
      DP_RND_ACC:  acc  <= rnd_val;
      DP_OUT_SUB:  res[cmd.joint] <= sat_cmd(sub_w);
      DP_OUT_ACC:  res[cmd.joint] <= sat_cmd(acc);
      DP_OUT_REF:  res[cmd.joint] <= ref_sel;
      DP_OUT_ZERO: res[cmd.joint] <= '0;
      DP_PUBLISH: begin
        command_a <= res[0];
        command_b <= res[1];
        command_c <= res[2];
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/jjpd_ctrl.sv -----
// Controller: sequences jog, per-joint multiply passes and result handoff.
`default_nettype none

module jjpd_ctrl
  import jjpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] drive_mode,
  output dp_cmd_t    cmd
);

  state_t     state;
  state_t     state_next;
  logic [1:0] joint;
  logic [1:0] joint_next;
  logic       out_valid_next;
  logic       torque;
  logic       velocity;
  logic       out_free;

  assign torque   = drive_mode == MODE_TORQUE;
  assign velocity = drive_mode == MODE_VELOCITY;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      joint     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      joint     <= joint_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    joint_next = joint;
    case (state)
      S_IDLE: if (in_valid) state_next = S_JNUM;
      S_JNUM: state_next = S_JEST;
      S_JEST: state_next = S_JFIX;
      S_JFIX: state_next = S_REF;
      S_REF: begin
        joint_next = 2'd0;
        state_next = (torque || velocity) ? S_ERR : S_OUT;
      end
      S_ERR:  state_next = S_PLO;
      S_PLO:  state_next = S_PHI;
      S_PHI:  state_next = S_PRND;
      S_PRND: state_next = torque ? S_DIFF : S_RLO;
      S_DIFF: state_next = S_RLO;
      S_RLO:  state_next = S_RHI;
      S_RHI:  state_next = S_RRND;
      S_RRND: state_next = torque ? S_DLO : S_OUT;
      S_DLO:  state_next = S_DHI;
      S_DHI:  state_next = S_DRND;
      S_DRND: state_next = S_OUT;
      S_OUT: begin
        if (joint == 2'd2) begin
          state_next = S_DONE;
        end else begin
          joint_next = joint + 2'd1;
          state_next = (torque || velocity) ? S_ERR : S_OUT;
        end
      end
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = DP_NOP;
    cmd.coef  = COEF_RATE;
    cmd.sh12  = 1'b0;
    cmd.joint = joint;
    in_stall  = state != S_IDLE;
    out_valid_next = (out_valid && !out_stall) ? 1'b0 : out_valid;
    case (state)
      S_IDLE: if (in_valid) cmd.op = DP_CAPTURE;
      S_JNUM: cmd.op = DP_JOG_NUM;
      S_JEST: cmd.op = DP_JOG_EST;
      S_JFIX: cmd.op = DP_JOG_FIX;
      S_REF:  cmd.op = DP_REF_UPD;
      S_ERR:  cmd.op = DP_X_ERR;
      S_PLO: begin
        cmd.op   = DP_MUL_LO;
        cmd.coef = COEF_KP;
      end
      S_PHI: begin
        cmd.op   = DP_MUL_HI;
        cmd.coef = COEF_KP;
      end
      S_PRND: begin
        cmd.op   = torque ? DP_RND_T : DP_RND_X;
        cmd.sh12 = 1'b1;
      end
      S_DIFF: cmd.op = DP_X_DIFF;
      S_RLO:  cmd.op = DP_MUL_LO;
      S_RHI:  cmd.op = DP_MUL_HI;
      S_RRND: cmd.op = torque ? DP_RND_X : DP_RND_ACC;
      S_DLO: begin
        cmd.op   = DP_MUL_LO;
        cmd.coef = COEF_KD;
      end
      S_DHI: begin
        cmd.op   = DP_MUL_HI;
        cmd.coef = COEF_KD;
      end
      S_DRND: begin
        cmd.op   = DP_RND_ACC;
        cmd.sh12 = 1'b1;
      end
      S_OUT: begin
        case (drive_mode)
          MODE_TORQUE:   cmd.op = DP_OUT_SUB;
          MODE_VELOCITY: cmd.op = DP_OUT_ACC;
          MODE_POSITION: cmd.op = DP_OUT_REF;
          default:       cmd.op = DP_OUT_ZERO;
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op         = DP_PUBLISH;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_PUBLISH) |-> (!out_valid || !out_stall))
    else $error("result published over a word not yet taken");

  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_PUBLISH) |=> (out_valid && state == S_IDLE))
    else $error("publish did not raise out_valid");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_JNUM))
    else $error("accepted word did not start the jog sequence");

  a_last_joint: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && joint == 2'd2) |=> (state == S_DONE))
    else $error("joint sequence overran");
`endif

endmodule

`default_nettype wire

// ----- rtl/joystick_jog_pd_joint_control.sv -----
// Top level of the joystick jog PD joint controller: configuration registers and core.
`default_nettype none

// One input word carries a joystick axis and three measured joint angles; one output word
// carries three commands (PD torque, velocity or position per drive_mode, zero in the
// unused mode). Each word runs through the jog and reference update (numerator, estimate,
// fix, reference), then in torque and velocity mode through the three joints in turn on
// one shared 21x25 multiplier that takes two passes per product. A new word is accepted
// only once the previous result has been published; that result is held in an output
// register, so the next word is taken while it still waits. Configuration writes are taken
// every cycle and belong only in idle periods.
module joystick_jog_pd_joint_control
  import jjpd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [AXIS_W-1:0]  stick_axis,
  input  logic signed [ANGLE_W-1:0] angle_a,
  input  logic signed [ANGLE_W-1:0] angle_b,
  input  logic signed [ANGLE_W-1:0] angle_c,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [CMD_W-1:0]   command_a,
  output logic signed [CMD_W-1:0]   command_b,
  output logic signed [CMD_W-1:0]   command_c,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_mode   <= MODE_TORQUE;
      cfg.rate_scale   <= 24'd256000;
      cfg.prop_gain[0] <= 24'd4096000;
      cfg.prop_gain[1] <= 24'd4096000;
      cfg.prop_gain[2] <= 24'd2457600;
      cfg.damp_gain[0] <= 24'd409600;
      cfg.damp_gain[1] <= 24'd409600;
      cfg.damp_gain[2] <= 24'd245760;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DRIVE_MODE:  cfg.drive_mode   <= cfg_data[1:0];
        REG_RATE_SCALE:  cfg.rate_scale   <= cfg_data;
        REG_PROP_GAIN_A: cfg.prop_gain[0] <= cfg_data;
        REG_PROP_GAIN_B: cfg.prop_gain[1] <= cfg_data;
        REG_PROP_GAIN_C: cfg.prop_gain[2] <= cfg_data;
        REG_DAMP_GAIN_A: cfg.damp_gain[0] <= cfg_data;
        REG_DAMP_GAIN_B: cfg.damp_gain[1] <= cfg_data;
        REG_DAMP_GAIN_C: cfg.damp_gain[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  jjpd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .drive_mode (cfg.drive_mode),
    .cmd        (cmd)
  );

  jjpd_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .stick_axis (stick_axis),
    .angle_a    (angle_a),
    .angle_b    (angle_b),
    .angle_c    (angle_c),
    .command_a  (command_a),
    .command_b  (command_b),
    .command_c  (command_c)
  );

endmodule

`default_nettype wire
